>>> design/asfj_pkg.sv
// Shared types, constants and floating-point helpers for the axial spring block.
package asfj_pkg;

  localparam int unsigned DIV_STEPS  = 28;
  localparam int unsigned SQRT_STEPS = 28;
  localparam int unsigned LAT_ADD    = 4;
  localparam int unsigned LAT_MUL    = 3;
  localparam int unsigned LAT_DIV    = DIV_STEPS + 2;
  localparam int unsigned LAT_SQRT   = SQRT_STEPS + 2;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] edge_x;
    logic [31:0] edge_y;
    logic [31:0] edge_z;
    logic [31:0] first_disp_x;
    logic [31:0] first_disp_y;
    logic [31:0] first_disp_z;
    logic [31:0] second_disp_x;
    logic [31:0] second_disp_y;
    logic [31:0] second_disp_z;
    logic [31:0] stiffness;
  } in_word_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [31:0] tan_xx;
    logic [31:0] tan_xy;
    logic [31:0] tan_xz;
    logic [31:0] tan_yx;
    logic [31:0] tan_yy;
    logic [31:0] tan_yz;
    logic [31:0] tan_zx;
    logic [31:0] tan_zy;
    logic [31:0] tan_zz;
  } out_word_t;

  typedef struct packed {
    logic               sgn;
    logic signed [10:0] ex;
    logic [23:0]        man;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sgn;
  } fp_cls_t;

  // Subnormal inputs are normalized so that the leading one sits in bit 23.
  function automatic fp_unp_t unpack(input logic [31:0] a);
    fp_unp_t     u;
    logic [23:0] m;
    logic [4:0]  k;
    u.sgn  = a[31];
    u.nan  = (&a[30:23]) & (|a[22:0]);
    u.inf  = (&a[30:23]) & ~(|a[22:0]);
    u.zero = ~(|a[30:0]);
    m = {1'b0, a[22:0]};
    k = '0;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) k = 5'(23 - i);
    end
    if (|a[30:23]) begin
      u.man = {1'b1, a[22:0]};
      u.ex  = $signed({3'b000, a[30:23]});
    end else begin
      u.man = m << k;
      u.ex  = 11'sd1 - $signed({6'b000000, k});
    end
    return u;
  endfunction

  // The mantissa carries its leading one in bit 26, then guard, round and sticky bits.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [10:0] ex,
                                             input logic [26:0] m);
    logic [26:0]        ms;
    logic [26:0]        lost;
    logic signed [10:0] sh;
    logic [7:0]         eb;
    logic               inc;
    logic [24:0]        mr;
    logic [30:0]        mag;
    ms   = m;
    lost = '0;
    eb   = '0;
    sh   = '0;
    if (ex <= 11'sd0) begin
      sh = 11'sd1 - ex;
      if (sh > 11'sd26) begin
        ms = {26'b0, |m};
      end else begin
        lost = m & ~({27{1'b1}} << sh[4:0]);
        ms   = (m >> sh[4:0]) | {26'b0, |lost};
      end
    end else begin
      eb = ex[7:0] - 8'd1;
    end
    inc = ms[2] & (ms[3] | ms[1] | ms[0]);
    mr  = {1'b0, ms[26:3]} + {24'b0, inc};
    mag = {eb, 23'b0} + {6'b0, mr};
    if (ex >= 11'sd255) begin
      return {sgn, INF_BITS[30:0]};
    end
    return {sgn, mag};
  endfunction

endpackage

>>> design/asfj_stream_if.sv
// Valid/ready stream channel carrying one word per handshake.
interface asfj_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

>>> design/asfj_delay.sv
// Enabled shift line that keeps operands aligned with the arithmetic stages.
module asfj_delay #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];
endmodule

>>> design/asfj_fadd.sv
// Four-stage binary32 adder with round to nearest even.
module asfj_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  logic              a_big;
  logic [31:0]       big, sml;
  logic [7:0]        e_big_nxt, e_sml;
  asfj_pkg::fp_cls_t cls_nxt;

  logic              s1_sb_r, s1_ss_r;
  logic [7:0]        s1_e_r, s1_d_r;
  logic [23:0]       s1_mb_r, s1_ms_r;
  asfj_pkg::fp_cls_t s1_cls_r;

  logic [26:0] mb27, ms27, al, lost;
  logic [27:0] s2_m_nxt;

  logic [27:0]       s2_m_r;
  logic [7:0]        s2_e_r;
  logic              s2_sgn_r, s2_zs_r;
  asfj_pkg::fp_cls_t s2_cls_r;

  logic [4:0]         lz;
  logic [26:0]        s3_m_nxt;
  logic signed [10:0] s3_e_nxt;

  logic [26:0]        s3_m_r;
  logic signed [10:0] s3_e_r;
  logic               s3_sgn_r, s3_zs_r, s3_zero_r;
  asfj_pkg::fp_cls_t  s3_cls_r;

  logic [31:0] y_nxt, y_r;

  always_comb begin
    a_big     = a[30:0] >= b[30:0];
    big       = a_big ? a : b;
    sml       = a_big ? b : a;
    e_big_nxt = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml     = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    cls_nxt.nan = ((&a[30:23]) & (|a[22:0])) | ((&b[30:23]) & (|b[22:0])) |
                  ((a[30:0] == asfj_pkg::INF_BITS[30:0]) &
                   (b[30:0] == asfj_pkg::INF_BITS[30:0]) & (a[31] ^ b[31]));
    cls_nxt.inf  = (a[30:0] == asfj_pkg::INF_BITS[30:0]) |
                   (b[30:0] == asfj_pkg::INF_BITS[30:0]);
    cls_nxt.sgn  = (a[30:0] == asfj_pkg::INF_BITS[30:0]) ? a[31] : b[31];
    cls_nxt.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sb_r  <= big[31];
      s1_ss_r  <= sml[31];
      s1_e_r   <= e_big_nxt;
      s1_d_r   <= e_big_nxt - e_sml;
      s1_mb_r  <= {|big[30:23], big[22:0]};
      s1_ms_r  <= {|sml[30:23], sml[22:0]};
      s1_cls_r <= cls_nxt;
    end
  end

  always_comb begin
    mb27 = {s1_mb_r, 3'b000};
    ms27 = {s1_ms_r, 3'b000};
    lost = '0;
    if (s1_d_r > 8'd26) begin
      al = {26'b0, |s1_ms_r};
    end else begin
      lost = ms27 & ~({27{1'b1}} << s1_d_r[4:0]);
      al   = (ms27 >> s1_d_r[4:0]) | {26'b0, |lost};
    end
    if (s1_sb_r != s1_ss_r) begin
      s2_m_nxt = {1'b0, mb27} - {1'b0, al};
    end else begin
      s2_m_nxt = {1'b0, mb27} + {1'b0, al};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m_r   <= s2_m_nxt;
      s2_e_r   <= s1_e_r;
      s2_sgn_r <= s1_sb_r;
      s2_zs_r  <= s1_sb_r & s1_ss_r;
      s2_cls_r <= s1_cls_r;
    end
  end

  always_comb begin
    lz = '0;
    for (int i = 0; i < 27; i++) begin
      if (s2_m_r[i]) lz = 5'(26 - i);
    end
    if (s2_m_r[27]) begin
      s3_m_nxt = {s2_m_r[27:2], |s2_m_r[1:0]};
      s3_e_nxt = $signed({3'b000, s2_e_r}) + 11'sd1;
    end else begin
      s3_m_nxt = s2_m_r[26:0] << lz;
      s3_e_nxt = $signed({3'b000, s2_e_r}) - $signed({6'b000000, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_m_r    <= s3_m_nxt;
      s3_e_r    <= s3_e_nxt;
      s3_sgn_r  <= s2_sgn_r;
      s3_zs_r   <= s2_zs_r;
      s3_zero_r <= ~(|s2_m_r);
      s3_cls_r  <= s2_cls_r;
    end
  end

  always_comb begin
    if (s3_cls_r.nan) begin
      y_nxt = asfj_pkg::CANON_NAN;
    end else if (s3_cls_r.inf) begin
      y_nxt = {s3_cls_r.sgn, asfj_pkg::INF_BITS[30:0]};
    end else if (s3_zero_r) begin
      y_nxt = {s3_zs_r, 31'b0};
    end else begin
      y_nxt = asfj_pkg::round_pack(s3_sgn_r, s3_e_r, s3_m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;
endmodule

>>> design/asfj_fmul.sv
// Three-stage binary32 multiplier with round to nearest even.
module asfj_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  asfj_pkg::fp_unp_t ua, ub;
  asfj_pkg::fp_cls_t cls_nxt;

  logic signed [10:0] s1_e_r;
  logic [23:0]        s1_ma_r, s1_mb_r;
  asfj_pkg::fp_cls_t  s1_cls_r;

  logic signed [10:0] s2_e_r;
  logic [47:0]        s2_p_r;
  asfj_pkg::fp_cls_t  s2_cls_r;

  logic [26:0]        m27;
  logic signed [10:0] e_fin;
  logic [31:0]        y_nxt, y_r;

  always_comb begin
    ua = asfj_pkg::unpack(a);
    ub = asfj_pkg::unpack(b);
    cls_nxt.nan  = ua.nan | ub.nan | (ua.inf & ub.zero) | (ua.zero & ub.inf);
    cls_nxt.inf  = ua.inf | ub.inf;
    cls_nxt.zero = ua.zero | ub.zero;
    cls_nxt.sgn  = ua.sgn ^ ub.sgn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e_r   <= ua.ex + ub.ex - 11'sd127;
      s1_ma_r  <= ua.man;
      s1_mb_r  <= ub.man;
      s1_cls_r <= cls_nxt;
      s2_e_r   <= s1_e_r;
      s2_p_r   <= s1_ma_r * s1_mb_r;
      s2_cls_r <= s1_cls_r;
    end
  end

  always_comb begin
    if (s2_p_r[47]) begin
      m27   = {s2_p_r[47:22], |s2_p_r[21:0]};
      e_fin = s2_e_r + 11'sd1;
    end else begin
      m27   = {s2_p_r[46:21], |s2_p_r[20:0]};
      e_fin = s2_e_r;
    end
    if (s2_cls_r.nan) begin
      y_nxt = asfj_pkg::CANON_NAN;
    end else if (s2_cls_r.inf) begin
      y_nxt = {s2_cls_r.sgn, asfj_pkg::INF_BITS[30:0]};
    end else if (s2_cls_r.zero) begin
      y_nxt = {s2_cls_r.sgn, 31'b0};
    end else begin
      y_nxt = asfj_pkg::round_pack(s2_cls_r.sgn, e_fin, m27);
    end
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;
endmodule

>>> design/asfj_fdiv.sv
// Pipelined binary32 divider, one restoring quotient bit per stage.
module asfj_fdiv (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  localparam int unsigned STEPS = asfj_pkg::DIV_STEPS;

  asfj_pkg::fp_unp_t ua, ub;
  asfj_pkg::fp_cls_t cls_nxt;

  logic [24:0]        rem_r [STEPS+1];
  logic [23:0]        dvs_r [STEPS+1];
  logic [27:0]        quo_r [STEPS+1];
  logic signed [10:0] ex_r  [STEPS+1];
  asfj_pkg::fp_cls_t  cls_r [STEPS+1];

  logic [27:0]        q_fin;
  logic [26:0]        m27;
  logic signed [10:0] e_fin;
  logic               st;
  logic [31:0]        y_nxt, y_r;

  always_comb begin
    ua = asfj_pkg::unpack(a);
    ub = asfj_pkg::unpack(b);
    cls_nxt.nan  = ua.nan | ub.nan | (ua.zero & ub.zero) | (ua.inf & ub.inf);
    cls_nxt.inf  = ua.inf | ub.zero;
    cls_nxt.zero = ua.zero | ub.inf;
    cls_nxt.sgn  = ua.sgn ^ ub.sgn;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {1'b0, ua.man};
      dvs_r[0] <= ub.man;
      quo_r[0] <= '0;
      ex_r[0]  <= ua.ex - ub.ex + 11'sd127;
      cls_r[0] <= cls_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic        ge;
    logic [24:0] dif;
    always_comb begin
      ge  = rem_r[k] >= {1'b0, dvs_r[k]};
      dif = ge ? (rem_r[k] - {1'b0, dvs_r[k]}) : rem_r[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= {dif[23:0], 1'b0};
        dvs_r[k+1] <= dvs_r[k];
        quo_r[k+1] <= {quo_r[k][26:0], ge};
        ex_r[k+1]  <= ex_r[k];
        cls_r[k+1] <= cls_r[k];
      end
    end
  end

  always_comb begin
    q_fin = quo_r[STEPS];
    st    = |rem_r[STEPS];
    if (q_fin[27]) begin
      m27   = {q_fin[27:2], q_fin[1] | q_fin[0] | st};
      e_fin = ex_r[STEPS];
    end else begin
      m27   = {q_fin[26:1], q_fin[0] | st};
      e_fin = ex_r[STEPS] - 11'sd1;
    end
    if (cls_r[STEPS].nan) begin
      y_nxt = asfj_pkg::CANON_NAN;
    end else if (cls_r[STEPS].inf) begin
      y_nxt = {cls_r[STEPS].sgn, asfj_pkg::INF_BITS[30:0]};
    end else if (cls_r[STEPS].zero) begin
      y_nxt = {cls_r[STEPS].sgn, 31'b0};
    end else begin
      y_nxt = asfj_pkg::round_pack(cls_r[STEPS].sgn, e_fin, m27);
    end
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;
endmodule

>>> design/asfj_fsqrt.sv
// Pipelined binary32 square root, one root bit per stage.
module asfj_fsqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  output logic [31:0] y
);
  localparam int unsigned STEPS = asfj_pkg::SQRT_STEPS;

  asfj_pkg::fp_unp_t  ua;
  asfj_pkg::fp_cls_t  cls_nxt;
  logic signed [10:0] p_raw, p_even;
  logic [24:0]        m25;

  logic [55:0]        rad_r  [STEPS+1];
  logic [29:0]        rem_r  [STEPS+1];
  logic [27:0]        root_r [STEPS+1];
  logic signed [10:0] hp_r   [STEPS+1];
  asfj_pkg::fp_cls_t  cls_r  [STEPS+1];

  logic [27:0]        r_fin;
  logic [26:0]        m27;
  logic signed [10:0] e_fin;
  logic               st;
  logic [31:0]        y_nxt, y_r;

  always_comb begin
    ua    = asfj_pkg::unpack(a);
    p_raw = ua.ex - 11'sd150;
    if (p_raw[0]) begin
      m25    = {ua.man, 1'b0};
      p_even = p_raw - 11'sd1;
    end else begin
      m25    = {1'b0, ua.man};
      p_even = p_raw;
    end
    cls_nxt.zero = ua.zero;
    cls_nxt.nan  = ua.nan | (a[31] & ~ua.zero);
    cls_nxt.inf  = ua.inf;
    cls_nxt.sgn  = a[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= {1'b0, m25, 30'b0};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      hp_r[0]   <= p_even >>> 1;
      cls_r[0]  <= cls_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic        ge;
    logic [31:0] rs, tr, dif;
    always_comb begin
      rs  = {rem_r[k], rad_r[k][55:54]};
      tr  = {2'b00, root_r[k], 2'b01};
      ge  = rs >= tr;
      dif = ge ? (rs - tr) : rs;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][53:0], 2'b00};
        rem_r[k+1]  <= dif[29:0];
        root_r[k+1] <= {root_r[k][26:0], ge};
        hp_r[k+1]   <= hp_r[k];
        cls_r[k+1]  <= cls_r[k];
      end
    end
  end

  always_comb begin
    r_fin = root_r[STEPS];
    st    = |rem_r[STEPS];
    if (r_fin[27]) begin
      m27   = {r_fin[27:2], r_fin[1] | r_fin[0] | st};
      e_fin = hp_r[STEPS] + 11'sd139;
    end else begin
      m27   = {r_fin[26:1], r_fin[0] | st};
      e_fin = hp_r[STEPS] + 11'sd138;
    end
    if (cls_r[STEPS].zero) begin
      y_nxt = {cls_r[STEPS].sgn, 31'b0};
    end else if (cls_r[STEPS].nan) begin
      y_nxt = asfj_pkg::CANON_NAN;
    end else if (cls_r[STEPS].inf) begin
      y_nxt = asfj_pkg::INF_BITS;
    end else begin
      y_nxt = asfj_pkg::round_pack(1'b0, e_fin, m27);
    end
  end

  always_ff @(posedge clk) begin
    if (en) y_r <= y_nxt;
  end

  assign y = y_r;
endmodule

>>> design/axial_spring_force_jacobian_core.sv
// Top level: spring element force and tangent on a fully pipelined binary32 datapath.
//
//   channel  direction  word                          handshake
//   in_ch    sink       edge, both displacements, K   valid/ready
//   out_ch   source     force vector, 3x3 tangent     valid/ready
//
// One word enters per cycle while no finished result is held back; the longest path runs
// through two adders, three multipliers, one square root and three dividers.
// Reset clears only the valid bits of the pipeline.
// When a finished result is not taken, the whole pipeline holds and in_ch.ready drops.
module axial_spring_force_jacobian_core #(
  parameter int DIMENSION = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  asfj_stream_if.sink          in_ch,
  asfj_stream_if.source        out_ch
);
  localparam int TL   = 2 * asfj_pkg::LAT_ADD;
  localparam int TN0  = asfj_pkg::LAT_MUL + 2 * asfj_pkg::LAT_ADD + asfj_pkg::LAT_SQRT;
  localparam int TLN  = TL + TN0;
  localparam int TDIR = TN0 + asfj_pkg::LAT_DIV;
  localparam int TDK  = TDIR + asfj_pkg::LAT_MUL;
  localparam int TST  = TLN + asfj_pkg::LAT_ADD;
  localparam int TA   = TDK + asfj_pkg::LAT_MUL;
  localparam int TC   = TA + asfj_pkg::LAT_DIV;
  localparam int TOUT = TC + asfj_pkg::LAT_DIV;

  logic            en;
  logic [TOUT-1:0] vld_r;

  logic [31:0] l0_in [3], u0_in [3], u1_in [3];
  logic [31:0] s_v [3], u0_d [3], l_v [3], sq0 [3], sql [3];
  logic [31:0] l0_d [3], dir_v [3], dk_v [3], t1_v [3], f_v [3], f_d [3], l_d [3];
  logic [31:0] a_v [3][3], c_v [3][3], d_v [3][3];
  logic [31:0] p0, p1, sq0z_d, sqlz_d, ss0, ss1, n0, ln, n0_st, stretch, st_d;
  logic [31:0] k_d, ln_a, n0_a, n0_c;
  asfj_pkg::out_word_t ow;

  assign en          = ~vld_r[TOUT-1] | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOUT-2:0], in_ch.valid};
    end
  end

  assign l0_in[0] = in_ch.word.edge_x;
  assign l0_in[1] = in_ch.word.edge_y;
  assign l0_in[2] = (DIMENSION == 2) ? 32'd0 : in_ch.word.edge_z;
  assign u0_in[0] = in_ch.word.first_disp_x;
  assign u0_in[1] = in_ch.word.first_disp_y;
  assign u0_in[2] = (DIMENSION == 2) ? 32'd0 : in_ch.word.first_disp_z;
  assign u1_in[0] = in_ch.word.second_disp_x;
  assign u1_in[1] = in_ch.word.second_disp_y;
  assign u1_in[2] = (DIMENSION == 2) ? 32'd0 : in_ch.word.second_disp_z;

  for (genvar i = 0; i < 3; i++) begin : g_vec
    asfj_fadd u_s (.clk, .en, .a(l0_in[i]), .b(u1_in[i]), .y(s_v[i]));
    asfj_delay #(.WIDTH(32), .DEPTH(asfj_pkg::LAT_ADD)) u_u0d (
      .clk, .en, .d(u0_in[i]), .q(u0_d[i]));
    asfj_fadd u_l (.clk, .en, .a(s_v[i]), .b({~u0_d[i][31], u0_d[i][30:0]}), .y(l_v[i]));
    asfj_fmul u_sq0 (.clk, .en, .a(l0_in[i]), .b(l0_in[i]), .y(sq0[i]));
    asfj_fmul u_sql (.clk, .en, .a(l_v[i]), .b(l_v[i]), .y(sql[i]));
    asfj_delay #(.WIDTH(32), .DEPTH(TN0)) u_l0d (.clk, .en, .d(l0_in[i]), .q(l0_d[i]));
    asfj_fdiv u_dir (.clk, .en, .a(l0_d[i]), .b(n0), .y(dir_v[i]));
    asfj_fmul u_dk (.clk, .en, .a(dir_v[i]), .b(k_d), .y(dk_v[i]));
    asfj_fmul u_t1 (.clk, .en, .a(dk_v[i]), .b(st_d), .y(t1_v[i]));
    asfj_fdiv u_f (.clk, .en, .a(t1_v[i]), .b(n0_a), .y(f_v[i]));
    asfj_delay #(.WIDTH(32), .DEPTH(asfj_pkg::LAT_DIV)) u_fd (
      .clk, .en, .d(f_v[i]), .q(f_d[i]));
    asfj_delay #(.WIDTH(32), .DEPTH(TDK - TL)) u_ld (.clk, .en, .d(l_v[i]), .q(l_d[i]));
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      asfj_fmul u_a (.clk, .en, .a(dk_v[i]), .b(l_d[j]), .y(a_v[i][j]));
      asfj_fdiv u_c (.clk, .en, .a(a_v[i][j]), .b(ln_a), .y(c_v[i][j]));
      asfj_fdiv u_d (.clk, .en, .a(c_v[i][j]), .b(n0_c), .y(d_v[i][j]));
    end
  end

  asfj_fadd u_p0 (.clk, .en, .a(sq0[0]), .b(sq0[1]), .y(p0));
  asfj_delay #(.WIDTH(32), .DEPTH(asfj_pkg::LAT_ADD)) u_sq0z (
    .clk, .en, .d(sq0[2]), .q(sq0z_d));
  asfj_fadd u_ss0 (.clk, .en, .a(p0), .b(sq0z_d), .y(ss0));
  asfj_fsqrt u_n0 (.clk, .en, .a(ss0), .y(n0));

  asfj_fadd u_p1 (.clk, .en, .a(sql[0]), .b(sql[1]), .y(p1));
  asfj_delay #(.WIDTH(32), .DEPTH(asfj_pkg::LAT_ADD)) u_sqlz (
    .clk, .en, .d(sql[2]), .q(sqlz_d));
  asfj_fadd u_ss1 (.clk, .en, .a(p1), .b(sqlz_d), .y(ss1));
  asfj_fsqrt u_ln (.clk, .en, .a(ss1), .y(ln));

  asfj_delay #(.WIDTH(32), .DEPTH(TLN - TN0)) u_n0st (.clk, .en, .d(n0), .q(n0_st));
  asfj_fadd u_st (.clk, .en, .a(ln), .b({~n0_st[31], n0_st[30:0]}), .y(stretch));
  asfj_delay #(.WIDTH(32), .DEPTH(TDK - TST)) u_std (.clk, .en, .d(stretch), .q(st_d));
  asfj_delay #(.WIDTH(32), .DEPTH(TDIR)) u_kd (
    .clk, .en, .d(in_ch.word.stiffness), .q(k_d));
  asfj_delay #(.WIDTH(32), .DEPTH(TA - TLN)) u_lna (.clk, .en, .d(ln), .q(ln_a));
  asfj_delay #(.WIDTH(32), .DEPTH(TA - TN0)) u_n0a (.clk, .en, .d(n0), .q(n0_a));
  asfj_delay #(.WIDTH(32), .DEPTH(TC - TN0)) u_n0c (.clk, .en, .d(n0), .q(n0_c));

  always_comb begin
    ow.force_x = f_d[0];
    ow.force_y = f_d[1];
    ow.force_z = (DIMENSION == 2) ? 32'd0 : f_d[2];
    ow.tan_xx  = d_v[0][0];
    ow.tan_xy  = d_v[0][1];
    ow.tan_xz  = (DIMENSION == 2) ? 32'd0 : d_v[0][2];
    ow.tan_yx  = d_v[1][0];
    ow.tan_yy  = d_v[1][1];
    ow.tan_yz  = (DIMENSION == 2) ? 32'd0 : d_v[1][2];
    ow.tan_zx  = (DIMENSION == 2) ? 32'd0 : d_v[2][0];
    ow.tan_zy  = (DIMENSION == 2) ? 32'd0 : d_v[2][1];
    ow.tan_zz  = (DIMENSION == 2) ? 32'd0 : d_v[2][2];
  end

  assign out_ch.word  = ow;
  assign out_ch.valid = vld_r[TOUT-1];
endmodule
